FILE: rtl/assert_macros.svh
// Assertion macros shared by the glyph downscaler RTL.
// Needs a clock named clk and an active-high reset named rst in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk, suspended while rst is high.
`define BGD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define BGD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/bgd_pkg.sv
// Package of the bilinear glyph downscaler: field widths, register indexes,
// reset values, item structs and the blend control struct. Depends on nothing.
package bgd_pkg;

  localparam int MAX_SRC_WIDTH_DEF  = 32;
  localparam int MAX_SRC_HEIGHT_DEF = 32;
  localparam int MAX_DST_WIDTH_DEF  = 16;

  localparam int PIXEL_W    = 8;
  localparam int SRC_COL_W  = 5;
  localparam int SRC_ROW_W  = 5;
  localparam int OUT_ROW_W  = 5;
  localparam int OUT_COL_W  = 4;
  localparam int SRC_DIM_W  = 6;
  localparam int DST_W_W    = 5;
  localparam int DST_H_W    = 6;
  localparam int STEP_W     = 22;
  localparam int FRAC_W     = 16;
  localparam int WEIGHT_W   = FRAC_W + 1;
  localparam int LIN_W      = WEIGHT_W + PIXEL_W;
  localparam int PROD_W     = WEIGHT_W + LIN_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;

  localparam logic [WEIGHT_W-1:0] ONE_Q16 = WEIGHT_W'(1) << FRAC_W;

  localparam logic [SRC_DIM_W-1:0] SRC_WIDTH_RST  = 6'd19;
  localparam logic [SRC_DIM_W-1:0] SRC_HEIGHT_RST = 6'd25;
  localparam logic [DST_W_W-1:0]   DST_WIDTH_RST  = 5'd14;
  localparam logic [DST_H_W-1:0]   DST_HEIGHT_RST = 6'd18;
  localparam logic [STEP_W-1:0]    STEP_X_RST     = 22'd88941;
  localparam logic [STEP_W-1:0]    STEP_Y_RST     = 22'd91022;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_TARGET_WIDTH  = 3'd2,
    REG_TARGET_HEIGHT = 3'd3,
    REG_STEP_X        = 3'd4,
    REG_STEP_Y        = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    REQ_WRITE_PIXEL = 1'b0,
    REQ_ROW         = 1'b1
  } req_kind_e;

  typedef struct packed {
    logic                 req_type;
    logic [SRC_COL_W-1:0] src_col;
    logic [SRC_ROW_W-1:0] src_row;
    logic [PIXEL_W-1:0]   pixel_in;
    logic [OUT_ROW_W-1:0] out_row;
  } req_item_t;

  typedef struct packed {
    logic [PIXEL_W-1:0]   pixel_out;
    logic [OUT_COL_W-1:0] out_col;
    logic                 last;
    logic                 row_bad;
  } res_item_t;

  // Strobes from the sequencer to the blend datapath.
  typedef struct packed {
    logic cap_p11;
    logic cap_p21;
    logic cap_p12;
    logic lin;
    logic mul;
  } blend_ctl_t;

endpackage

FILE: rtl/bgd_glyph_ram.sv
// Source glyph store: one write port and one read port with registered read data.
// Depends on bgd_pkg for the pixel width.
module bgd_glyph_ram
  import bgd_pkg::*;
#(
  parameter int DEPTH  = MAX_SRC_WIDTH_DEF * MAX_SRC_HEIGHT_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  logic [PIXEL_W-1:0] wdata,
  input  logic               re,
  input  logic [ADDR_W-1:0]  raddr,
  output logic [PIXEL_W-1:0] rdata
);

  logic [PIXEL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/bgd_blend.sv
// Bilinear blend datapath: captures three neighbors, takes the fourth straight from the
// read data, blends horizontally, then vertically. Depends on bgd_pkg for widths and the blend control struct.
module bgd_blend
  import bgd_pkg::*;
(
  input  logic               clk,
  input  blend_ctl_t         ctl,
  input  logic [FRAC_W-1:0]  fx,
  input  logic [FRAC_W-1:0]  fy,
  input  logic [PIXEL_W-1:0] rdata,
  output logic [PIXEL_W-1:0] pixel_out
);

  logic [PIXEL_W-1:0]  p11;
  logic [PIXEL_W-1:0]  p21;
  logic [PIXEL_W-1:0]  p12;
  logic [LIN_W-1:0]    top;
  logic [LIN_W-1:0]    bot;
  logic [PROD_W-1:0]   prod_top;
  logic [PROD_W-1:0]   prod_bot;
  logic [PROD_W-1:0]   sum;
  logic [WEIGHT_W-1:0] wx0;
  logic [WEIGHT_W-1:0] wx1;
  logic [WEIGHT_W-1:0] wy0;
  logic [WEIGHT_W-1:0] wy1;

  assign wx1 = WEIGHT_W'(fx);
  assign wy1 = WEIGHT_W'(fy);
  assign wx0 = ONE_Q16 - wx1;
  assign wy0 = ONE_Q16 - wy1;

  // The read of the lower-right neighbor lands in the lin cycle, so it is
  // used straight from the memory output.
  always_ff @(posedge clk) begin
    if (ctl.cap_p11) begin
      p11 <= rdata;
    end
    if (ctl.cap_p21) begin
      p21 <= rdata;
    end
    if (ctl.cap_p12) begin
      p12 <= rdata;
    end
    if (ctl.lin) begin
      top <= LIN_W'(wx0 * LIN_W'(p11)) + LIN_W'(wx1 * LIN_W'(p21));
      bot <= LIN_W'(wx0 * LIN_W'(p12)) + LIN_W'(wx1 * LIN_W'(rdata));
    end
    if (ctl.mul) begin
      prod_top <= PROD_W'(wy0) * PROD_W'(top);
      prod_bot <= PROD_W'(wy1) * PROD_W'(bot);
    end
  end

  // The exact sum stays below 2^40, so the top byte of the Q32 result is kept.
  assign sum       = prod_top + prod_bot;
  assign pixel_out = sum[2*FRAC_W +: PIXEL_W];

endmodule

FILE: rtl/bilinear_glyph_downscale_core.sv
// Top level of the bilinear glyph downscaler: configuration registers, row
// sequencer and output register. Uses bgd_pkg, bgd_glyph_ram and bgd_blend.
//
//   channel  | signals                          | direction | moves
//   ---------+----------------------------------+-----------+------------------------
//   request  | req_valid, req_stall, req_item   | in        | pixel write or row item
//   result   | res_valid, res_stall, res_item   | out       | one output pixel item
//   config   | cfg_we, cfg_index, cfg_data      | in        | register write
//
// A pixel write item is written to the glyph store in the cycle it is
// accepted. A row request for a valid row first passes the ROWMUL and ROWCLP
// steps; then, for each output pixel up to the clamped target width, the
// single read port of the glyph store fetches the four neighbors one after the
// other, followed by a horizontal blend, a vertical multiply and the emit
// step. A request for a bad row passes through S_BAD, which loads its single
// item into the output register once the output slot is free.
// Reset (synchronous, rst high) returns the sequencer to idle, empties the
// output register and loads the register defaults; the glyph store keeps its
// contents and is undefined until written. While a result item waits under
// res_stall the sequencer holds in its emit step; new requests are taken only
// in idle, and idle is reachable while the last result item still waits.
`include "assert_macros.svh"
module bilinear_glyph_downscale_core
  import bgd_pkg::*;
#(
  parameter int MAX_SRC_WIDTH  = MAX_SRC_WIDTH_DEF,
  parameter int MAX_SRC_HEIGHT = MAX_SRC_HEIGHT_DEF,
  parameter int MAX_DST_WIDTH  = MAX_DST_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_item_t             req_item,
  output logic                  res_valid,
  input  logic                  res_stall,
  output res_item_t             res_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int X_W    = $clog2(MAX_SRC_WIDTH);
  localparam int Y_W    = $clog2(MAX_SRC_HEIGHT);
  localparam int SW_W   = $clog2(MAX_SRC_WIDTH + 1);
  localparam int SH_W   = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int TW_W   = $clog2(MAX_DST_WIDTH + 1);
  localparam int PX_W   = STEP_W + TW_W;
  localparam int IXR_W  = PX_W - FRAC_W;
  localparam int PY_W   = OUT_ROW_W + STEP_W;
  localparam int IYR_W  = PY_W - FRAC_W;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_BAD    = 12'b0000_0000_0010,
    S_ROWMUL = 12'b0000_0000_0100,
    S_ROWCLP = 12'b0000_0000_1000,
    S_COLX   = 12'b0000_0001_0000,
    S_RD11   = 12'b0000_0010_0000,
    S_RD21   = 12'b0000_0100_0000,
    S_RD12   = 12'b0000_1000_0000,
    S_RD22   = 12'b0001_0000_0000,
    S_LIN    = 12'b0010_0000_0000,
    S_MUL    = 12'b0100_0000_0000,
    S_EMIT   = 12'b1000_0000_0000
  } state_t;

  // Configuration registers.
  logic [SRC_DIM_W-1:0] source_width;
  logic [SRC_DIM_W-1:0] source_height;
  logic [DST_W_W-1:0]   target_width;
  logic [DST_H_W-1:0]   target_height;
  logic [STEP_W-1:0]    step_x;
  logic [STEP_W-1:0]    step_y;

  // Sequencer state and per-row, per-pixel working registers.
  state_t              state;
  state_t              state_next;
  logic [OUT_ROW_W-1:0] orow;
  logic [PY_W-1:0]     py;
  logic [PX_W-1:0]     px;
  logic [TW_W-1:0]     col;
  logic [FRAC_W-1:0]   fx;
  logic [FRAC_W-1:0]   fy;
  logic [X_W-1:0]      ix;
  logic [X_W-1:0]      x2;
  logic [ADDR_W-1:0]   base_top;
  logic [ADDR_W-1:0]   base_bot;

  // Clamped sizes.
  logic [SW_W-1:0] sw_eff;
  logic [SH_W-1:0] sh_eff;
  logic [TW_W-1:0] tw_eff;
  logic [X_W-1:0]  sw_last;
  logic [Y_W-1:0]  sh_last;
  logic [TW_W-1:0] tw_last;

  logic [IXR_W-1:0] ix_raw;
  logic [IYR_W-1:0] iy_raw;
  logic [X_W-1:0]   ix_c;
  logic [X_W-1:0]   x2_c;
  logic [Y_W-1:0]   iy_c;
  logic [Y_W-1:0]   y2_c;

  logic               req_accept;
  logic               res_free;
  logic               col_is_last;
  logic               row_is_bad;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [PIXEL_W-1:0] mem_rdata;
  logic [PIXEL_W-1:0] blend_pixel;
  blend_ctl_t         blend_ctl;

  assign req_stall  = (state != S_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign res_free   = !res_valid || !res_stall;
  assign row_is_bad = (DST_H_W'(req_item.out_row) >= target_height);

  // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SRC_WIDTH_RST;
      source_height <= SRC_HEIGHT_RST;
      target_width  <= DST_WIDTH_RST;
      target_height <= DST_HEIGHT_RST;
      step_x        <= STEP_X_RST;
      step_y        <= STEP_Y_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH:  source_width  <= cfg_data[SRC_DIM_W-1:0];
        REG_SOURCE_HEIGHT: source_height <= cfg_data[SRC_DIM_W-1:0];
        REG_TARGET_WIDTH:  target_width  <= cfg_data[DST_W_W-1:0];
        REG_TARGET_HEIGHT: target_height <= cfg_data[DST_H_W-1:0];
        REG_STEP_X:        step_x        <= cfg_data[STEP_W-1:0];
        REG_STEP_Y:        step_y        <= cfg_data[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sizes of zero or beyond the built maximum saturate into the legal range.
  always_comb begin
    if (source_width == '0) begin
      sw_eff = SW_W'(1);
    end else if (int'(source_width) > MAX_SRC_WIDTH) begin
      sw_eff = SW_W'(MAX_SRC_WIDTH);
    end else begin
      sw_eff = SW_W'(source_width);
    end
    if (source_height == '0) begin
      sh_eff = SH_W'(1);
    end else if (int'(source_height) > MAX_SRC_HEIGHT) begin
      sh_eff = SH_W'(MAX_SRC_HEIGHT);
    end else begin
      sh_eff = SH_W'(source_height);
    end
    if (target_width == '0) begin
      tw_eff = TW_W'(1);
    end else if (int'(target_width) > MAX_DST_WIDTH) begin
      tw_eff = TW_W'(MAX_DST_WIDTH);
    end else begin
      tw_eff = TW_W'(target_width);
    end
  end

  assign sw_last     = X_W'(sw_eff - SW_W'(1));
  assign sh_last     = Y_W'(sh_eff - SH_W'(1));
  assign tw_last     = tw_eff - TW_W'(1);
  assign col_is_last = (col == tw_last);

  // Integer positions past the glyph saturate to its last column or row, and
  // the second neighbor is held at that edge as well.
  assign ix_raw = px[PX_W-1:FRAC_W];
  assign iy_raw = py[PY_W-1:FRAC_W];

  always_comb begin
    if (ix_raw > IXR_W'(sw_last)) begin
      ix_c = sw_last;
    end else begin
      ix_c = X_W'(ix_raw);
    end
    x2_c = (ix_c == sw_last) ? sw_last : ix_c + X_W'(1);
    if (iy_raw > IYR_W'(sh_last)) begin
      iy_c = sh_last;
    end else begin
      iy_c = Y_W'(iy_raw);
    end
    y2_c = (iy_c == sh_last) ? sh_last : iy_c + Y_W'(1);
  end

  // Next-state logic of the row sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_accept && req_item.req_type == REQ_ROW) begin
          state_next = row_is_bad ? S_BAD : S_ROWMUL;
        end
      end
      S_BAD: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      S_ROWMUL: state_next = S_ROWCLP;
      S_ROWCLP: state_next = S_COLX;
      S_COLX:   state_next = S_RD11;
      S_RD11:   state_next = S_RD21;
      S_RD21:   state_next = S_RD12;
      S_RD12:   state_next = S_RD22;
      S_RD22:   state_next = S_LIN;
      S_LIN:    state_next = S_MUL;
      S_MUL:    state_next = S_EMIT;
      S_EMIT: begin
        if (res_free) begin
          state_next = col_is_last ? S_IDLE : S_COLX;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers; none of them needs a reset.
  always_ff @(posedge clk) begin
    if (req_accept) begin
      orow <= req_item.out_row;
    end
    if (state == S_ROWMUL) begin
      py <= PY_W'(orow) * PY_W'(step_y);
    end
    if (state == S_ROWCLP) begin
      fy       <= py[FRAC_W-1:0];
      base_top <= ADDR_W'(iy_c * MAX_SRC_WIDTH);
      base_bot <= ADDR_W'(y2_c * MAX_SRC_WIDTH);
      px       <= '0;
      col      <= '0;
    end
    if (state == S_COLX) begin
      fx <= px[FRAC_W-1:0];
      ix <= ix_c;
      x2 <= x2_c;
    end
    if (state == S_EMIT && res_free && !col_is_last) begin
      px  <= px + PX_W'(step_x);
      col <= col + TW_W'(1);
    end
  end

  // Glyph store ports. Writes happen only in idle and reads only inside a row,
  // so the sequencer itself keeps the two from touching the same entry at once.
  assign mem_we = req_accept && req_item.req_type == REQ_WRITE_PIXEL &&
                  int'(req_item.src_col) < MAX_SRC_WIDTH &&
                  int'(req_item.src_row) < MAX_SRC_HEIGHT;
  assign mem_waddr = ADDR_W'(req_item.src_row * MAX_SRC_WIDTH + req_item.src_col);

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = base_top + ADDR_W'(ix);
    unique case (state)
      S_RD11: begin
        mem_re    = 1'b1;
        mem_raddr = base_top + ADDR_W'(ix);
      end
      S_RD21: begin
        mem_re    = 1'b1;
        mem_raddr = base_top + ADDR_W'(x2);
      end
      S_RD12: begin
        mem_re    = 1'b1;
        mem_raddr = base_bot + ADDR_W'(ix);
      end
      S_RD22: begin
        mem_re    = 1'b1;
        mem_raddr = base_bot + ADDR_W'(x2);
      end
      default: begin
      end
    endcase
  end

  // The first three neighbors are each captured in the cycle after their read was issued; the fourth is used directly.
  assign blend_ctl.cap_p11 = (state == S_RD21);
  assign blend_ctl.cap_p21 = (state == S_RD12);
  assign blend_ctl.cap_p12 = (state == S_RD22);
  assign blend_ctl.lin     = (state == S_LIN);
  assign blend_ctl.mul     = (state == S_MUL);

  bgd_glyph_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (req_item.pixel_in),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bgd_blend u_blend (
    .clk       (clk),
    .ctl       (blend_ctl),
    .fx        (fx),
    .fy        (fy),
    .rdata     (mem_rdata),
    .pixel_out (blend_pixel)
  );

  // Output register: a new item is loaded when the slot is empty or its
  // current item is being taken in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free && (state == S_EMIT || state == S_BAD)) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && state == S_EMIT) begin
      res_item.pixel_out <= blend_pixel;
      res_item.out_col   <= OUT_COL_W'(col);
      res_item.last      <= col_is_last;
      res_item.row_bad   <= 1'b0;
    end else if (res_free && state == S_BAD) begin
      res_item.pixel_out <= '0;
      res_item.out_col   <= '0;
      res_item.last      <= 1'b1;
      res_item.row_bad   <= 1'b1;
    end
  end

  `BGD_ASSERT(a_res_from_seq,
    $rose(res_valid) |-> ($past(state) == S_EMIT || $past(state) == S_BAD),
    "result item appeared outside the emit steps")
  `BGD_ASSERT(a_bad_shape,
    (res_valid && res_item.row_bad) |-> (res_item.last && res_item.out_col == '0),
    "bad-row item must be a lone last item at column zero")
  `BGD_ASSERT(a_raddr_range,
    mem_re |-> (int'(mem_raddr) < DEPTH),
    "glyph read address beyond the store")
  `BGD_ASSERT(a_col_clamped,
    (state == S_RD11) |-> (ix <= sw_last && x2 <= sw_last),
    "neighbor column beyond the source width")
  `BGD_ASSERT_ALWAYS(a_reset_idle,
    rst |=> (state == S_IDLE && !res_valid),
    "sequencer not idle after reset")

endmodule
